// File: hw/rtl/dhti_pkg.sv
`timescale 1ns / 1ps

package dhti_pkg;

  // table geometry
  localparam int TABLE_SIZE = 37;
  localparam int STEP_PRIME = 13;

  // field widths
  localparam int KEY_W    = 31;
  localparam int STATUS_W = 3;
  localparam int CMP_W    = 6;

  // derived widths
  localparam int POS_W  = $clog2(TABLE_SIZE);
  localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
  localparam int STEP_W = $clog2(STEP_PRIME + 1);

  // reciprocals for the remainders by the table size and the step prime,
  // exact for every key below 2**KEY_W
  localparam int REC_W    = KEY_W + 1;
  localparam int REC_T_SH = KEY_W + $clog2(TABLE_SIZE);
  localparam int REC_P_SH = KEY_W + $clog2(STEP_PRIME);
  localparam logic [REC_W-1:0] REC_T = REC_W'(
    ((64'd1 << REC_T_SH) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE));
  localparam logic [REC_W-1:0] REC_P = REC_W'(
    ((64'd1 << REC_P_SH) + 64'(STEP_PRIME - 1)) / 64'(STEP_PRIME));

  // job queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // slot marks
  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_USED    = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  // hashed operation handed from front to back
  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] step;
  } job_t;

  // one table slot
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [1:0]       mark;
  } slot_t;

  // count to result field, wraps at the field width
  function automatic logic [CMP_W-1:0] to_cmp(input logic [CNT_W-1:0] v);
    logic [CNT_W+CMP_W-1:0] w;
    w = {{CMP_W{1'b0}}, v};
    return w[CMP_W-1:0];
  endfunction

endpackage

// File: hw/rtl/dhti_front.sv
`timescale 1ns / 1ps

module dhti_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  input  logic [dhti_pkg::KEY_W-1:0]     key,
  output logic                           push_valid,
  input  logic                           push_stall,
  output dhti_pkg::job_t                 push_job
);

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV,
    F_REM,
    F_FDIV,
    F_FOLD,
    F_PUSH
  } fstate_t;

  localparam int KEY_W  = dhti_pkg::KEY_W;
  localparam int POS_W  = dhti_pkg::POS_W;
  localparam int STEP_W = dhti_pkg::STEP_W;
  localparam int PROD_W = dhti_pkg::KEY_W + dhti_pkg::REC_W;
  localparam int FOLD_W = dhti_pkg::STEP_W + dhti_pkg::POS_W;

  fstate_t                        state;
  logic                           op;
  logic [KEY_W-1:0]               key_q;
  logic [KEY_W-1:0]               q_t;
  logic [KEY_W-1:0]               q_p;
  logic [STEP_W-1:0]              q_s;
  logic [STEP_W-1:0]              step_raw;
  logic [POS_W-1:0]               r_t;
  logic [POS_W-1:0]               r_s;

  logic [PROD_W-1:0]              prod_t;
  logic [PROD_W-1:0]              prod_p;
  logic [PROD_W-1:0]              prod_s;
  logic [KEY_W-1:0]               rem_t;
  logic [KEY_W-1:0]               rem_p;
  logic [FOLD_W-1:0]              fold;

  // quotients by reciprocal multiplication, remainders by multiply and subtract
  always_comb begin
    prod_t = PROD_W'(key_q) * PROD_W'(dhti_pkg::REC_T);
    prod_p = PROD_W'(key_q) * PROD_W'(dhti_pkg::REC_P);
    prod_s = PROD_W'(step_raw) * PROD_W'(dhti_pkg::REC_T);
    rem_t  = key_q - q_t * KEY_W'(dhti_pkg::TABLE_SIZE);
    rem_p  = key_q - q_p * KEY_W'(dhti_pkg::STEP_PRIME);
    fold   = FOLD_W'(step_raw) - FOLD_W'(q_s) * FOLD_W'(dhti_pkg::TABLE_SIZE);
  end

  assign in_stall      = (state != F_IDLE);
  assign push_valid    = (state == F_PUSH);
  assign push_job.op   = op;
  assign push_job.key  = key_q;
  assign push_job.pos  = r_t;
  assign push_job.step = r_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            op    <= opcode;
            key_q <= key;
            state <= F_DIV;
          end
        end
        F_DIV: begin
          q_t   <= KEY_W'(prod_t >> dhti_pkg::REC_T_SH);
          q_p   <= KEY_W'(prod_p >> dhti_pkg::REC_P_SH);
          state <= F_REM;
        end
        F_REM: begin
          r_t      <= POS_W'(rem_t);
          step_raw <= STEP_W'(rem_p) + STEP_W'(1);
          state    <= F_FDIV;
        end
        F_FDIV: begin
          // fold the step into the table range
          q_s   <= STEP_W'(prod_s >> dhti_pkg::REC_T_SH);
          state <= F_FOLD;
        end
        F_FOLD: begin
          r_s   <= POS_W'(fold);
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!push_stall) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/dhti_queue.sv
`timescale 1ns / 1ps

module dhti_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_stall,
  input  dhti_pkg::job_t  push_job,
  output logic            pop_valid,
  input  logic            pop_take,
  output dhti_pkg::job_t  pop_job
);

  dhti_pkg::job_t                  entry [dhti_pkg::QDEPTH];
  logic [dhti_pkg::QPTR_W-1:0]     wr_ptr;
  logic [dhti_pkg::QPTR_W-1:0]     rd_ptr;
  logic [dhti_pkg::QCNT_W-1:0]     count;
  logic                            do_push;
  logic                            do_pop;

  assign push_stall = (count == dhti_pkg::QCNT_W'(dhti_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = entry[rd_ptr];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_take && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + dhti_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + dhti_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + dhti_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - dhti_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/dhti_back.sv
`timescale 1ns / 1ps

module dhti_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              job_valid,
  output logic                              job_take,
  input  dhti_pkg::job_t                    job,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dhti_pkg::STATUS_W-1:0]     status,
  output logic [dhti_pkg::CMP_W-1:0]        comparisons
);

  typedef enum logic {
    B_IDLE,
    B_RUN
  } bstate_t;

  localparam int POS_W = dhti_pkg::POS_W;
  localparam int CNT_W = dhti_pkg::CNT_W;
  localparam logic [POS_W:0] T_EXT = (POS_W + 1)'(dhti_pkg::TABLE_SIZE);

  // slot store, read data registered
  dhti_pkg::slot_t                  mem [dhti_pkg::TABLE_SIZE];
  logic [dhti_pkg::TABLE_SIZE-1:0]  live;
  dhti_pkg::slot_t                  rd_entry;
  logic                             rd_live;
  logic [POS_W-1:0]                 rd_addr;
  logic                             wr_en;
  logic [POS_W-1:0]                 wr_addr;
  dhti_pkg::slot_t                  wr_entry;

  bstate_t                          state;
  logic                             op;
  logic [dhti_pkg::KEY_W-1:0]       key_q;
  logic [POS_W-1:0]                 step;
  logic [POS_W-1:0]                 ev_pos;
  logic [CNT_W-1:0]                 ev_cnt;
  logic [CNT_W-1:0]                 cmp;
  logic                             phase2;
  logic [POS_W-1:0]                 save;

  logic [1:0]                       mark;
  logic                             used;
  logic                             hit;
  logic                             at_end;
  logic [CNT_W-1:0]                 cmp_inc;
  logic [POS_W:0]                   pos_sum;
  logic [POS_W-1:0]                 pos_next;
  logic                             done;
  logic [dhti_pkg::STATUS_W-1:0]    done_status;
  logic [CNT_W-1:0]                 done_cmp;
  logic [CNT_W-1:0]                 cmp_next;
  logic                             phase2_next;
  logic [POS_W-1:0]                 save_next;
  logic                             out_free;
  logic                             go;

  always_comb begin
    mark     = rd_live ? rd_entry.mark : dhti_pkg::MARK_EMPTY;
    used     = (mark == dhti_pkg::MARK_USED);
    hit      = used && (rd_entry.key == key_q);
    at_end   = (ev_cnt == CNT_W'(dhti_pkg::TABLE_SIZE));
    cmp_inc  = cmp + CNT_W'(1);
    pos_sum  = {1'b0, ev_pos} + {1'b0, step};
    pos_next = (pos_sum >= T_EXT) ? POS_W'(pos_sum - T_EXT) : POS_W'(pos_sum);
  end

  // probe decision for the slot whose data is on the read port
  always_comb begin
    done           = 1'b0;
    done_status    = dhti_pkg::ST_NOT_FOUND;
    done_cmp       = cmp;
    cmp_next       = cmp;
    phase2_next    = phase2;
    save_next      = save;
    wr_en          = 1'b0;
    wr_addr        = ev_pos;
    wr_entry.key   = key_q;
    wr_entry.mark  = dhti_pkg::MARK_USED;
    if (op == dhti_pkg::OP_INSERT && !phase2) begin
      if (at_end) begin
        done        = 1'b1;
        done_status = dhti_pkg::ST_FULL;
        done_cmp    = ev_cnt;
      end else if (hit) begin
        done        = 1'b1;
        done_status = dhti_pkg::ST_DUPLICATE;
        done_cmp    = cmp_inc;
      end else if (used) begin
        cmp_next = cmp_inc;
      end else if (mark == dhti_pkg::MARK_EMPTY) begin
        done        = 1'b1;
        done_status = dhti_pkg::ST_INSERTED;
        wr_en       = 1'b1;
      end else begin
        // first free slot is a tombstone: keep looking for a duplicate
        phase2_next = 1'b1;
        save_next   = ev_pos;
      end
    end else if (op == dhti_pkg::OP_INSERT) begin
      if (at_end || mark == dhti_pkg::MARK_EMPTY) begin
        done        = 1'b1;
        done_status = dhti_pkg::ST_INSERTED;
        wr_en       = 1'b1;
        wr_addr     = save;
      end else if (hit) begin
        done        = 1'b1;
        done_status = dhti_pkg::ST_DUPLICATE;
        done_cmp    = cmp_inc;
      end else if (used) begin
        cmp_next = cmp_inc;
      end
    end else begin
      if (at_end || mark == dhti_pkg::MARK_EMPTY) begin
        done        = 1'b1;
        done_status = dhti_pkg::ST_NOT_FOUND;
      end else if (hit) begin
        done          = 1'b1;
        done_status   = dhti_pkg::ST_DELETED;
        done_cmp      = cmp_inc;
        wr_en         = 1'b1;
        wr_entry.mark = dhti_pkg::MARK_DELETED;
      end else if (used) begin
        cmp_next = cmp_inc;
      end
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign go       = (state == B_RUN) && (!done || out_free);
  assign job_take = (state == B_IDLE) && job_valid;

  // next read: the job's first slot when idle, the following probe, or the same slot again while held
  always_comb begin
    if (state == B_IDLE) begin
      rd_addr = job.pos;
    end else if (go && !done) begin
      rd_addr = pos_next;
    end else begin
      rd_addr = ev_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (go && wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= '0;
      rd_live <= 1'b0;
    end else begin
      if (go && wr_en) begin
        live[wr_addr] <= 1'b1;
      end
      rd_live <= live[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (go && done) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            op     <= job.op;
            key_q  <= job.key;
            step   <= job.step;
            ev_pos <= job.pos;
            ev_cnt <= '0;
            cmp    <= '0;
            phase2 <= 1'b0;
            state  <= B_RUN;
          end
        end
        B_RUN: begin
          if (go) begin
            if (done) begin
              status      <= done_status;
              comparisons <= dhti_pkg::to_cmp(done_cmp);
              state       <= B_IDLE;
            end else begin
              ev_pos <= pos_next;
              ev_cnt <= ev_cnt + CNT_W'(1);
              cmp    <= cmp_next;
              phase2 <= phase2_next;
              save   <= save_next;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/double_hash_table_insert_delete_top.sv
`timescale 1ns / 1ps

// open-addressed key table with double hashing, insert and delete
//
// input channel: in_valid / in_stall with opcode (0 insert, 1 delete) and a
// 31-bit key; an item is taken at an edge with in_valid high, in_stall low
// output channel: out_valid / out_stall with status and comparisons, one
// result item per input item, in input order
//
// the front hashes the key by reciprocal multiplication (key mod 37 and mod 13,
// then the step folded into the table range) and takes no new item until it has
// pushed the last; a two-entry job queue lets the front hash the next item while
// the back probes; the back reads one slot per cycle, unless a finished result
// waits on out_stall, from a registered-read slot memory, and visits each slot
// of the 37-slot table at most once per item; sustained throughput is set by the
// slower of the two, and an item waits longer when long probe walks are queued
// ahead of it
//
// reset empties the table at once (one live bit per slot) and drops any queued
// items; while out_stall holds a result, the back keeps probing and only waits
// when its next result is ready, and the front keeps hashing into the queue

module double_hash_table_insert_delete_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [dhti_pkg::KEY_W-1:0]        key,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dhti_pkg::STATUS_W-1:0]     status,
  output logic [dhti_pkg::CMP_W-1:0]        comparisons
);

  // front to queue
  logic            push_valid;
  logic            push_stall;
  dhti_pkg::job_t  push_job;

  // queue to back
  logic            pop_valid;
  logic            pop_take;
  dhti_pkg::job_t  pop_job;

  // hashing front end
  dhti_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .key        (key),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_job   (push_job)
  );

  // decouples hashing from probing
  dhti_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_take   (pop_take),
    .pop_job    (pop_job)
  );

  // probe engine, slot store and result register
  dhti_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (pop_valid),
    .job_take    (pop_take),
    .job         (pop_job),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .comparisons (comparisons)
  );

endmodule

// File: hw/rtl/dhti_checker.sv
`timescale 1ns / 1ps

module dhti_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [dhti_pkg::STATUS_W-1:0]     status,
  input  logic [dhti_pkg::CMP_W-1:0]        comparisons
);

  localparam logic [dhti_pkg::CMP_W-1:0] FULL_CMP =
    dhti_pkg::to_cmp(dhti_pkg::CNT_W'(dhti_pkg::TABLE_SIZE));

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(status) && $stable(comparisons))
    else $error("stalled result changed");

  // a full table means every slot was compared
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == dhti_pkg::ST_FULL |-> comparisons == FULL_CMP)
    else $error("full result with wrong count");

  // a hit always counts the matching slot
  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == dhti_pkg::ST_DELETED || status == dhti_pkg::ST_DUPLICATE)
    |-> (comparisons != '0) || (dhti_pkg::TABLE_SIZE > 62))
    else $error("hit result with zero count");

endmodule

bind double_hash_table_insert_delete_top dhti_checker u_dhti_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .comparisons (comparisons)
);
